// File: rtl/bta_pkg.sv
// Shared constants and helper functions for the buddy tree allocator.
`default_nettype none
package bta_pkg;

  localparam int unsigned UNITS     = 512;
  localparam int unsigned GROUPS    = 64;
  localparam int unsigned TOP_LAYER = 10;
  localparam int unsigned COARSE    = 7;

  localparam logic [15:0] GRP_L8_MASK  = 16'h0003;
  localparam logic [15:0] GRP_L9_MASK  = 16'h003C;
  localparam logic [15:0] GRP_L10_MASK = 16'h3FC0;
  localparam logic [15:0] GRP_RESET    = 16'hFFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [63:0] word_t;

  function automatic logic [3:0] grp_base(input int l);
    logic [3:0] b;
    b = (l == 0) ? 4'd0 : ((l == 1) ? 4'd2 : 4'd6);
    return b;
  endfunction

  function automatic word_t run_mask(input int start, input int cnt);
    word_t m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (i >= start) && (i < start + cnt);
    end
    return m;
  endfunction

  function automatic word_t layer_reset(input logic [3:0] l);
    word_t w;
    if (l >= 4'd8) begin
      w = '1;
    end else if (l == 4'd0) begin
      w = '0;
    end else begin
      w = run_mask(0, 1 << (int'(l) - 1));
    end
    return w;
  endfunction

  function automatic logic [15:0] grp_below(input logic [1:0] lvl, input logic [2:0] j);
    logic [15:0] m;
    int d;
    m = '0;
    for (int l = 0; l < 3; l++) begin
      if (l >= int'(lvl)) begin
        d = l - int'(lvl);
        for (int b = 0; b < 16; b++) begin
          if (b >= int'(grp_base(l)) + (int'(j) << d) &&
              b < int'(grp_base(l)) + (int'(j) << d) + (1 << d)) begin
            m[b] = 1'b1;
          end
        end
      end
    end
    return m;
  endfunction

  function automatic logic [15:0] grp_above(input logic [1:0] lvl, input logic [2:0] j);
    logic [15:0] m;
    int p;
    m = '0;
    for (int l = 0; l < 2; l++) begin
      if (l < int'(lvl)) begin
        p = int'(grp_base(l)) + (int'(j) >> (int'(lvl) - l));
        m[p[3:0]] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [5:0] low_bit64(input word_t w);
    logic [5:0] p;
    p = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (w[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [3:0] low_bit16(input logic [15:0] w);
    logic [3:0] p;
    p = 4'd15;
    for (int i = 15; i >= 0; i--) begin
      if (w[i]) p = 4'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/buddy_tree_allocator_core.sv
// Buddy allocator over 512 units with layer words and group trees in memories.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser operation, tdata size, address
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser alloc_failed, tdata block_address
//
// An allocate does a lookup, then a sweep over the layer memory with one
// read-modify-write per layer, then loads the result. A bad size or a failed
// lookup goes straight to the load. A free does a lookup, the same sweep, then,
// when the freed node can merge, a check state plus a layer read and write per
// merge step, up to 6 steps. Reset clears valid bits of both memories at once;
// an unwritten entry reads as its reset pattern. A stalled result holds in the
// output register; the next allocate waits at its end until that register is free.
`default_nettype none
module buddy_tree_allocator_core import bta_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [0:0]  s_axis_tuser,  // [0] operation
  input  wire  [23:0] s_axis_tdata,  // [9:0] request_size, [18:10] free_address
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [0:0]  m_axis_tuser,  // [0] alloc_failed
  output logic [15:0] m_axis_tdata   // [8:0] block_address
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ALC_RD  = 4'd1;
  localparam logic [3:0] S_GRP_RD  = 4'd2;
  localparam logic [3:0] S_FRE_TBL = 4'd3;
  localparam logic [3:0] S_FRE_GRP = 4'd4;
  localparam logic [3:0] S_SWEEP   = 4'd5;
  localparam logic [3:0] S_MRG     = 4'd6;
  localparam logic [3:0] S_MRG_WR  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  word_t       lfb_mem [0:10];
  logic [15:0] grp_mem [0:63];
  logic [9:0]  tbl_mem [0:511];

  logic        lrd_en, lwr_en;
  logic [3:0]  lrd_addr, lwr_addr, lrd_a_q;
  word_t       lwr_data, lrd_q, lw;
  logic [10:0] lvld_q;
  logic        lrd_v_q;

  logic        grd_en, gwr_en;
  logic [5:0]  grd_addr, gwr_addr;
  logic [15:0] gwr_data, grd_q, gw;
  logic [63:0] gvld_q;
  logic        grd_v_q;

  logic        trd_en, twr_en;
  logic [8:0]  trd_addr, twr_addr;
  logic [9:0]  twr_data, trd_q;

  logic [3:0]  st_q, st_d;
  logic        op_q, op_d;
  logic [3:0]  lay_q, lay_d;
  logic [5:0]  n_q, n_d;
  logic [2:0]  j_q, j_d;
  logic [8:0]  addr_q, addr_d;
  logic        fail_q, fail_d;
  logic [15:0] gtn_q, gtn_d;
  logic        full_q, full_d;
  logic [3:0]  sl_q, sl_d;
  logic [3:0]  k_q, k_d;
  logic [5:0]  nm_q, nm_d;
  word_t       cur_q, cur_d;
  logic        ov_q, ov_d;
  logic [8:0]  oa_q, oa_d;
  logic        of_q, of_d;

  always_ff @(posedge clk_i) begin
    if (lwr_en) lfb_mem[lwr_addr] <= lwr_data;
    if (lrd_en) lrd_q <= lfb_mem[lrd_addr];
    if (gwr_en) grp_mem[gwr_addr] <= gwr_data;
    if (grd_en) grd_q <= grp_mem[grd_addr];
    if (twr_en) tbl_mem[twr_addr] <= twr_data;
    if (trd_en) trd_q <= tbl_mem[trd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q  <= '0;
      gvld_q  <= '0;
      lrd_v_q <= 1'b0;
      lrd_a_q <= '0;
      grd_v_q <= 1'b0;
    end else begin
      if (lwr_en) lvld_q[lwr_addr] <= 1'b1;
      if (gwr_en) gvld_q[gwr_addr] <= 1'b1;
      if (lrd_en) begin
        lrd_v_q <= lvld_q[lrd_addr];
        lrd_a_q <= lrd_addr;
      end
      if (grd_en) grd_v_q <= gvld_q[grd_addr];
    end
  end

  assign lw = lrd_v_q ? lrd_q : layer_reset(lrd_a_q);
  assign gw = grd_v_q ? grd_q : GRP_RESET;

  function automatic word_t upd(input logic [3:0] l, input word_t w, input logic op,
                                input logic [3:0] lay, input logic [5:0] n,
                                input logic [15:0] gtn, input logic full);
    word_t r;
    word_t bn;
    int    sh;
    r  = w;
    bn = word_t'(1) << n;
    if (lay <= 4'd7) begin
      if (l < lay) begin
        if (op == OP_ALLOC) r = w & ~(word_t'(1) << (n >> (lay - l)));
      end else begin
        if (l == lay) begin
          r = (op == OP_ALLOC) ? (w & ~bn) : (w | bn);
        end else begin
          sh = ((l <= 4'd7) ? int'(l) : 7) - int'(lay);
          r = (op == OP_ALLOC) ? (w & ~run_mask(int'(n) << sh, 1 << sh))
                               : (w | run_mask(int'(n) << sh, 1 << sh));
        end
      end
    end else begin
      if (l < 4'd7) begin
        if (op == OP_ALLOC) r = w & ~(word_t'(1) << (n >> (4'd7 - l)));
      end else if (l == 4'd7) begin
        if (op == OP_ALLOC) r = w & ~bn;
        else if (full) r = w | bn;
      end else begin
        if (l == 4'd8) r = (|(gtn & GRP_L8_MASK)) ? (w | bn) : (w & ~bn);
        else if (l == 4'd9) r = (|(gtn & GRP_L9_MASK)) ? (w | bn) : (w & ~bn);
        else r = (|(gtn & GRP_L10_MASK)) ? (w | bn) : (w & ~bn);
      end
    end
    return r;
  endfunction

  logic [9:0]  in_size;
  logic [8:0]  in_addr;
  logic [8:0]  s1;
  logic [3:0]  clog;
  logic [3:0]  in_lay;
  logic [1:0]  lvl;
  logic [15:0] cand, gt_a, gt_f;
  logic [3:0]  p;
  logic [2:0]  jj;
  logic [3:0]  tl;
  logic [5:0]  tn;
  logic [2:0]  jf;
  logic [1:0]  lf;
  logic [3:0]  pos;
  logic        fullc;
  word_t       uw;
  logic [3:0]  lm;

  always_comb begin
    in_size = s_axis_tdata[9:0];
    in_addr = s_axis_tdata[18:10];
    s1      = 9'(in_size - 10'd1);
    clog    = '0;
    for (int i = 0; i < 9; i++) begin
      if (s1[i]) clog = 4'(i + 1);
    end
    in_lay = 4'd10 - clog;
  end

  always_comb begin
    st_d = st_q; op_d = op_q; lay_d = lay_q; n_d = n_q; j_d = j_q; addr_d = addr_q;
    fail_d = fail_q; gtn_d = gtn_q; full_d = full_q; sl_d = sl_q; k_d = k_q;
    nm_d = nm_q; cur_d = cur_q; ov_d = ov_q; oa_d = oa_q; of_d = of_q;
    lrd_en = 1'b0; lrd_addr = '0; lwr_en = 1'b0; lwr_addr = '0; lwr_data = '0;
    grd_en = 1'b0; grd_addr = '0; gwr_en = 1'b0; gwr_addr = '0; gwr_data = '0;
    trd_en = 1'b0; trd_addr = '0; twr_en = 1'b0; twr_addr = '0; twr_data = '0;
    lvl   = 2'(lay_q - 4'd8);
    cand  = '0;
    gt_a  = '0;
    gt_f  = '0;
    p     = '0;
    jj    = '0;
    tl    = trd_q[9:6];
    tn    = trd_q[5:0];
    jf    = j_q;
    lf    = lvl;
    pos   = '0;
    fullc = 1'b0;
    uw    = '0;
    lm    = (lay_q <= 4'd7) ? lay_q : 4'd7;

    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d   = s_axis_tuser[0];
          addr_d = in_addr;
          fail_d = 1'b0;
          full_d = 1'b0;
          if (s_axis_tuser[0] == OP_FREE) begin
            trd_en   = 1'b1;
            trd_addr = in_addr;
            st_d     = S_FRE_TBL;
          end else if (in_size == 10'd0 || in_size > 10'(UNITS)) begin
            fail_d = 1'b1;
            st_d   = S_DONE;
          end else begin
            lay_d    = in_lay;
            lrd_en   = 1'b1;
            lrd_addr = in_lay;
            st_d     = S_ALC_RD;
          end
        end
      end
      S_ALC_RD: begin
        if (lw == '0) begin
          fail_d = 1'b1;
          st_d   = S_DONE;
        end else begin
          n_d = low_bit64(lw);
          if (lay_q <= 4'd7) begin
            addr_d   = 9'(10'(low_bit64(lw)) << (4'd10 - lay_q));
            twr_en   = 1'b1;
            twr_addr = 9'(10'(low_bit64(lw)) << (4'd10 - lay_q));
            twr_data = {lay_q, low_bit64(lw)};
            lrd_en   = 1'b1;
            lrd_addr = 4'd1;
            sl_d     = 4'd1;
            st_d     = S_SWEEP;
          end else begin
            grd_en   = 1'b1;
            grd_addr = low_bit64(lw);
            st_d     = S_GRP_RD;
          end
        end
      end
      S_GRP_RD: begin
        cand = gw & 16'(run_mask(int'(grp_base(int'(lvl))), 2 << lvl));
        if (cand == '0) begin
          fail_d = 1'b1;
          st_d   = S_DONE;
        end else begin
          p        = low_bit16(cand);
          jj       = 3'(p - grp_base(int'(lvl)));
          gt_a     = gw & ~(grp_below(lvl, jj) | grp_above(lvl, jj));
          gtn_d    = gt_a;
          gwr_en   = 1'b1;
          gwr_addr = n_q;
          gwr_data = gt_a;
          addr_d   = 9'(((9'(n_q) << (lvl + 2'd1)) + 9'(jj)) << (2'd2 - lvl));
          twr_en   = 1'b1;
          twr_addr = 9'(((9'(n_q) << (lvl + 2'd1)) + 9'(jj)) << (2'd2 - lvl));
          twr_data = {lay_q, n_q};
          lrd_en   = 1'b1;
          lrd_addr = 4'd1;
          sl_d     = 4'd1;
          st_d     = S_SWEEP;
        end
      end
      S_FRE_TBL: begin
        lay_d = tl;
        if (tl >= 4'd1 && tl <= 4'd7) begin
          n_d      = tn & 6'((7'd1 << (tl - 4'd1)) - 7'd1);
          lrd_en   = 1'b1;
          lrd_addr = 4'd1;
          sl_d     = 4'd1;
          st_d     = S_SWEEP;
        end else if (tl >= 4'd8 && tl <= 4'd10) begin
          n_d      = tn;
          j_d      = 3'(addr_q >> (4'd10 - tl)) & 3'((4'd2 << (tl - 4'd8)) - 4'd1);
          grd_en   = 1'b1;
          grd_addr = tn;
          st_d     = S_FRE_GRP;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_FRE_GRP: begin
        gt_f = gw | grp_below(lvl, j_q);
        for (int s = 0; s < 2; s++) begin
          if (lf != 2'd0) begin
            pos = grp_base(int'(lf)) + 4'({jf[2:1], 1'b0});
            if (gt_f[pos] && gt_f[pos + 4'd1]) begin
              jf   = jf >> 1;
              lf   = lf - 2'd1;
              gt_f = gt_f | (16'd1 << (grp_base(int'(lf)) + 4'(jf)));
            end
          end
        end
        fullc  = 1'b0;
        if (lf == 2'd0 && gt_f[1:0] == 2'b11) fullc = 1'b1;
        full_d   = fullc;
        gtn_d    = gt_f;
        gwr_en   = 1'b1;
        gwr_addr = n_q;
        gwr_data = gt_f;
        lrd_en   = 1'b1;
        lrd_addr = 4'd1;
        sl_d     = 4'd1;
        st_d     = S_SWEEP;
      end
      S_SWEEP: begin
        uw       = upd(sl_q, lw, op_q, lay_q, n_q, gtn_q, full_q);
        lwr_en   = 1'b1;
        lwr_addr = sl_q;
        lwr_data = uw;
        if (sl_q == lm) cur_d = uw;
        if (sl_q != 4'd10) begin
          lrd_en   = 1'b1;
          lrd_addr = sl_q + 4'd1;
          sl_d     = sl_q + 4'd1;
        end else if (op_q == OP_FREE && (lay_q <= 4'd7 || full_q)) begin
          k_d  = lm;
          nm_d = n_q;
          st_d = S_MRG;
        end else begin
          st_d = (op_q == OP_ALLOC) ? S_DONE : S_IDLE;
        end
      end
      S_MRG: begin
        if (k_q > 4'd1 && cur_q[{nm_q[5:1], 1'b0}] && cur_q[{nm_q[5:1], 1'b1}]) begin
          lrd_en   = 1'b1;
          lrd_addr = k_q - 4'd1;
          st_d     = S_MRG_WR;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_MRG_WR: begin
        uw       = lw | (word_t'(1) << (nm_q >> 1));
        lwr_en   = 1'b1;
        lwr_addr = k_q - 4'd1;
        lwr_data = uw;
        cur_d    = uw;
        nm_d     = nm_q >> 1;
        k_d      = k_q - 4'd1;
        st_d     = S_MRG;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          ov_d = 1'b1;
          oa_d = fail_q ? 9'd0 : addr_q;
          of_d = fail_q;
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    lay_q  <= lay_d;
    n_q    <= n_d;
    j_q    <= j_d;
    addr_q <= addr_d;
    fail_q <= fail_d;
    gtn_q  <= gtn_d;
    full_q <= full_d;
    sl_q   <= sl_d;
    k_q    <= k_d;
    nm_q   <= nm_d;
    cur_q  <= cur_d;
    oa_q   <= oa_d;
    of_q   <= of_d;
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = of_q;
  assign m_axis_tdata  = {7'd0, oa_q};

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[8:0] == 9'd0)
    else $error("failed allocate carries a nonzero address");
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SWEEP |-> sl_q >= 4'd1 && sl_q <= 4'd10)
    else $error("sweep layer out of range");
  a_merge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_MRG_WR |-> k_q >= 4'd2 && k_q <= 4'd7)
    else $error("merge layer out of range");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DONE && m_axis_tvalid && !m_axis_tready |=> st_q == S_DONE)
    else $error("result overwrote a stalled beat");

endmodule
`default_nettype wire

// File: dv/tb_buddy_tree_allocator_core.sv
// Self-checking testbench for the buddy tree allocator core with a bit-level tree predictor.
`default_nettype none
module tb_buddy_tree_allocator_core import bta_pkg::*; ();

  typedef struct packed {
    logic [8:0] addr;
    logic       failed;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [0:0]  s_axis_tuser;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [0:0]  m_axis_tuser;
  logic [15:0] m_axis_tdata;

  buddy_tree_allocator_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata)
  );

  // predictor state
  logic [63:0] free_bits [0:10];
  logic [15:0] grp_bits [0:63];
  logic [3:0]  rec_layer [0:511];
  logic [5:0]  rec_node [0:511];
  grant_t      grants_due [$];
  logic [8:0]  live_blocks [$];

  int  fail_cnt;
  int  idle_pct;
  int  stall_pct;
  int  hold_cycles;
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] span(input int start, input int cnt);
    logic [63:0] m;
    if (cnt >= 64) return '1;
    m = ((64'd1 << cnt) - 64'd1) << start;
    return m;
  endfunction

  function automatic int first_one(input logic [63:0] v);
    for (int i = 0; i < 64; i++) begin
      if (v[i]) return i;
    end
    return 63;
  endfunction

  function automatic int gbase(input int l);
    return (l == 0) ? 0 : ((l == 1) ? 2 : 6);
  endfunction

  function automatic logic [15:0] subtree_mask(input int lvl, input int j);
    logic [63:0] m;
    m = '0;
    for (int l = lvl; l < 3; l++) begin
      m |= span(gbase(l) + (j << (l - lvl)), 1 << (l - lvl));
    end
    return m[15:0];
  endfunction

  function automatic void refresh_summary(input int g);
    free_bits[8][g]  = |(grp_bits[g] & GRP_L8_MASK);
    free_bits[9][g]  = |(grp_bits[g] & GRP_L9_MASK);
    free_bits[10][g] = |(grp_bits[g] & GRP_L10_MASK);
  endfunction

  function automatic void paint_below(input int k, input int n, input logic val);
    logic [63:0] m;
    for (int l = k + 1; l <= 7; l++) begin
      m = span(n << (l - k), 1 << (l - k));
      free_bits[l] = val ? (free_bits[l] | m) : (free_bits[l] & ~m);
    end
    m = span(n << (7 - k), 1 << (7 - k));
    for (int l = 8; l <= 10; l++) begin
      free_bits[l] = val ? (free_bits[l] | m) : (free_bits[l] & ~m);
    end
  endfunction

  function automatic void clear_above(input int k, input int n);
    while (k > 1) begin
      k--;
      n = n >> 1;
      free_bits[k][n] = 1'b0;
    end
  endfunction

  task automatic merge_buddies(input int k, input int n);
    while (k > 1) begin
      if (free_bits[k][n & ~1] !== 1'b1 || free_bits[k][n | 1] !== 1'b1) break;
      n = n >> 1;
      k--;
      free_bits[k][n] = 1'b1;
    end
  endtask

  task automatic reset_model();
    free_bits[0] = '0;
    for (int k = 1; k <= 7; k++) free_bits[k] = span(0, 1 << (k - 1));
    for (int k = 8; k <= 10; k++) free_bits[k] = '1;
    for (int g = 0; g < 64; g++) grp_bits[g] = 16'hFFFF;
    grants_due.delete();
    live_blocks.delete();
  endtask

  function automatic grant_t predict_alloc(input int size);
    grant_t r;
    int layer, n, lvl, p, j, a;
    logic [15:0] cand;
    r.addr = '0;
    r.failed = 1'b1;
    if (size == 0 || size > 512) return r;
    layer = 10;
    for (int t = size - 1; t != 0; t = t >> 1) layer--;
    if (free_bits[layer] == '0) return r;
    n = first_one(free_bits[layer]);
    if (layer <= 7) begin
      a = n << (10 - layer);
      free_bits[layer][n] = 1'b0;
      paint_below(layer, n, 1'b0);
      clear_above(layer, n);
    end else begin
      lvl = layer - 8;
      cand = grp_bits[n] & 16'(span(gbase(lvl), 2 << lvl));
      if (cand == '0) return r;
      p = first_one({48'd0, cand});
      j = p - gbase(lvl);
      a = ((n << (lvl + 1)) + j) << (2 - lvl);
      grp_bits[n] &= ~subtree_mask(lvl, j);
      for (int l = 0; l < lvl; l++) grp_bits[n][gbase(l) + (j >> (lvl - l))] = 1'b0;
      free_bits[7][n] = 1'b0;
      clear_above(7, n);
      refresh_summary(n);
    end
    a = a & 511;
    rec_layer[a] = 4'(layer);
    rec_node[a] = 6'(n);
    r.addr = 9'(a);
    r.failed = 1'b0;
    return r;
  endfunction

  task automatic predict_free(input int a);
    int layer, node, g, lvl, j, l;
    layer = rec_layer[a];
    node = rec_node[a];
    if (layer >= 1 && layer <= 7) begin
      node = node & ((1 << (layer - 1)) - 1);
      free_bits[layer][node] = 1'b1;
      paint_below(layer, node, 1'b1);
      merge_buddies(layer, node);
    end else if (layer >= 8 && layer <= 10) begin
      g = node;
      lvl = layer - 8;
      j = (a >> (10 - layer)) & ((2 << lvl) - 1);
      l = lvl;
      grp_bits[g] |= subtree_mask(lvl, j);
      while (l > 0) begin
        if (grp_bits[g][gbase(l) + (j & ~1)] !== 1'b1 ||
            grp_bits[g][gbase(l) + (j | 1)] !== 1'b1) break;
        j = j >> 1;
        l--;
        grp_bits[g][gbase(l) + j] = 1'b1;
      end
      if (l == 0 && grp_bits[g][1:0] == 2'b11) begin
        free_bits[7][g] = 1'b1;
        merge_buddies(7, g);
      end
      refresh_summary(g);
    end
  endtask

  task automatic send_beat(input logic op, input logic [9:0] size, input logic [8:0] a);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, a, size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_FREE) predict_free(a);
    else grants_due.push_back(predict_alloc(size));
  endtask

  task automatic alloc_beat(input int size);
    grant_t g;
    send_beat(OP_ALLOC, size[9:0], 9'($urandom));
    g = grants_due[$];
    if (!g.failed) live_blocks.push_back(g.addr);
  endtask

  task automatic free_beat(input int idx);
    logic [8:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_beat(OP_FREE, 10'($urandom), a);
  endtask

  task automatic free_all();
    while (live_blocks.size() > 0) free_beat($urandom_range(live_blocks.size() - 1));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (grants_due.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic int rand_size();
    int e;
    e = $urandom_range(9);
    if ($urandom_range(99) < 70) e = $urandom_range(3);
    return $urandom_range(1 << e, (e == 0) ? 1 : (1 << (e - 1)) + 1) ;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    alloc_beat(512);
    alloc_beat(1);
    alloc_beat(0);
    alloc_beat(1023);
    alloc_beat(513);
    free_all();
    alloc_beat(1);
    alloc_beat(2);
    alloc_beat(3);
    alloc_beat(5);
    alloc_beat(8);
    alloc_beat(9);
    alloc_beat(256);
    alloc_beat(256);
    alloc_beat(129);
    free_all();
    for (int i = 0; i < 8; i++) alloc_beat(64);
    alloc_beat(1);
    free_all();
    alloc_beat(511);
    free_all();
    drain();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (live_blocks.size() > 0 && $urandom_range(99) < 45) begin
        free_beat($urandom_range(live_blocks.size() - 1));
      end else if ($urandom_range(99) < 4) begin
        alloc_beat($urandom_range(1, 1023));
      end else begin
        alloc_beat(rand_size());
      end
    end
    free_all();
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) alloc_beat(rand_size());
    free_all();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    fail_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(450, 0, 0);
    test_random(450, 69, 0);
    test_random(450, 0, 69);
    test_random(450, 24, 24);
    test_backpressure();
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    grant_t g;
    if (m_axis_tvalid && m_axis_tready) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result beat addr=%0d failed=%0d", m_axis_tdata[8:0], m_axis_tuser[0]);
        fail_cnt++;
      end else begin
        g = grants_due.pop_front();
        if (m_axis_tdata[8:0] !== g.addr) begin
          $error("block_address expected %0d actual %0d", g.addr, m_axis_tdata[8:0]);
          fail_cnt++;
        end
        if (m_axis_tuser[0] !== g.failed) begin
          $error("alloc_failed expected %0d actual %0d", g.failed, m_axis_tuser[0]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial quiet_cycles = 0;

endmodule
`default_nettype wire
